// ----- sv/ssd_pkg.sv -----
package ssd_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 10;
  localparam int LEVEL_W  = 10;
  localparam int GAP_W    = 16;
  localparam int MINLEN_W = 16;
  localparam int START_W  = 24;
  localparam int LEN_W    = 25;
  localparam int COUNT_W  = 24;
  localparam int SIL_W    = 17;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int PROD_W   = MAG_W + GAIN_W;
  localparam int SHIFT    = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 80;

  localparam logic [SIL_W-1:0] SIL_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAP      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_WORD = 2'd3;

  // reset values of the configuration registers
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 10'd650;
  localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 10'd5;
  localparam logic [GAP_W-1:0]    GAP_RST    = 16'd1000;
  localparam logic [MINLEN_W-1:0] MINLEN_RST = 16'd1000;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [LEVEL_W-1:0]  level;
    logic [GAP_W-1:0]    gap_limit;
    logic [MINLEN_W-1:0] min_word_length;
  } cfg_t;

  typedef struct packed {
    logic                has_word;
    logic [START_W-1:0]  word_start;
    logic [LEN_W-1:0]    word_length;
    logic [COUNT_W-1:0]  word_count;
    logic                final_res;
  } result_t;

endpackage

// ----- sv/ssd_activity.sv -----
module ssd_activity (
  input  logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
  input  ssd_pkg::cfg_t                       cfg,
  output logic                                active
);
  import ssd_pkg::*;

  logic signed [MAG_W-1:0]  sample_ext;
  logic [MAG_W-1:0]         mag_in;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-SHIFT-1:0]  mag;

  // magnitude, scale by gain, drop 15 fraction bits, compare to level
  always_comb begin
    sample_ext = MAG_W'(sample);
    mag_in     = sample_ext[MAG_W-1] ? MAG_W'(-sample_ext) : MAG_W'(sample_ext);
    prod       = PROD_W'(mag_in) * PROD_W'(cfg.gain);
    mag        = prod[PROD_W-1:SHIFT];
    active     = (mag >= (PROD_W-SHIFT)'(cfg.level));
  end

endmodule

// ----- sv/ssd_tracker.sv -----
module ssd_tracker #(
  parameter int INDEX_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ssd_pkg::cfg_t     cfg,
  input  logic              step,
  input  logic              active,
  input  logic              last,
  output logic              emit,
  output ssd_pkg::result_t  res
);
  import ssd_pkg::*;

  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic                  in_word_r, in_word_nxt;
  logic [INDEX_BITS-1:0] begin_r, begin_nxt;
  logic [INDEX_BITS-1:0] last_act_r, last_act_nxt;
  logic [SIL_W-1:0]      sil_r, sil_nxt;
  logic [COUNT_W-1:0]    words_r, words_nxt;

  logic                  has;
  logic [INDEX_BITS-1:0] start;
  logic [INDEX_BITS:0]   len;
  logic [INDEX_BITS:0]   closed_len;
  logic [INDEX_BITS-1:0] span;
  logic [INDEX_BITS-1:0] closed_span;

  // word tracking for one sample
  always_comb begin
    idx_nxt      = idx_r + INDEX_BITS'(1);
    in_word_nxt  = in_word_r;
    begin_nxt    = begin_r;
    last_act_nxt = last_act_r;
    sil_nxt      = sil_r;
    has          = 1'b0;
    start        = begin_r;
    len          = '0;
    span         = '0;
    // spans wrap at the index width before the length gets its extra bit
    closed_span  = last_act_r - begin_r;
    closed_len   = {1'b0, closed_span} + (INDEX_BITS+1)'(1);
    if (active) begin
      if (!in_word_r) begin
        // leading silence joins the word when short enough
        if (sil_r <= SIL_W'(cfg.gap_limit)) begin
          begin_nxt = idx_r - INDEX_BITS'(sil_r[GAP_W-1:0]);
        end else begin
          begin_nxt = idx_r;
        end
        in_word_nxt = 1'b1;
      end
      last_act_nxt = idx_r;
      sil_nxt      = '0;
      start        = begin_nxt;
      if (last) begin
        has  = 1'b1;
        span = idx_r - begin_nxt;
        len  = {1'b0, span} + (INDEX_BITS+1)'(1);
      end
    end else begin
      if (sil_r != SIL_MAX) begin
        sil_nxt = sil_r + SIL_W'(1);
      end
      // close the word on a long gap or at stream end
      if (in_word_r && ((sil_nxt > SIL_W'(cfg.gap_limit)) || last)) begin
        if (closed_len > (INDEX_BITS+1)'(cfg.min_word_length)) begin
          has = 1'b1;
          len = closed_len;
        end
        in_word_nxt = 1'b0;
      end
    end
    words_nxt = words_r + COUNT_W'(has);
    emit      = has || last;

    res.has_word    = has;
    res.word_start  = has ? START_W'(start) : '0;
    res.word_length = has ? LEN_W'(len) : '0;
    res.word_count  = words_nxt;
    res.final_res   = last;
  end

  // stream state, cleared after the last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      in_word_r  <= 1'b0;
      begin_r    <= '0;
      last_act_r <= '0;
      sil_r      <= '0;
      words_r    <= '0;
    end else if (step) begin
      if (last) begin
        idx_r      <= '0;
        in_word_r  <= 1'b0;
        begin_r    <= '0;
        last_act_r <= '0;
        sil_r      <= '0;
        words_r    <= '0;
      end else begin
        idx_r      <= idx_nxt;
        in_word_r  <= in_word_nxt;
        begin_r    <= begin_nxt;
        last_act_r <= last_act_nxt;
        sil_r      <= sil_nxt;
        words_r    <= words_nxt;
      end
    end
  end

  // stream end returns the tracker to its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> idx_r == '0 && !in_word_r && words_r == '0 && sil_r == '0)
    else $error("stream state not cleared after last sample");

  // an active sample opens or keeps a word and ends the silent run
  a_active_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step && active && !last |=> in_word_r && sil_r == '0 && last_act_r == $past(idx_r))
    else $error("active sample did not update word state");

  // a short silent run inside a word keeps the word open
  a_gap_bridged: assert property (@(posedge clk) disable iff (!rst_n)
    step && !active && !last && in_word_r && (sil_nxt <= SIL_W'(cfg.gap_limit))
    |=> in_word_r)
    else $error("word closed inside a bridged gap");

  // a report only happens on the edge of a word
  a_report_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    step && has && !active |-> in_word_r)
    else $error("word reported with no open word");

endmodule

// ----- sv/speech_segment_detector_core.sv -----
// a sample is captured in the input register; its result beat is then registered in the result register
// throughput: one sample per cycle unless a result beat is stalled by out_tready; the multiply-compare
//   and word update sit between the input register and the result register
// samples that cause no result produce no output beat; the last sample always yields one
// reset (rst_n, synchronous): stream state cleared, configuration registers back to their defaults
module speech_segment_detector_core #(
  parameter int INDEX_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ssd_pkg::SAMPLE_W-1:0]       in_tdata,   // sample[15:0]
  input  logic                               in_tlast,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ssd_pkg::OUT_DATA_W-1:0]     out_tdata,  // word_start[23:0], word_length[48:24],
                                                         // word_count[72:49], zeros[79:73]
  output logic                               out_tuser,  // has_word
  output logic                               out_tlast,  // final_res
  // configuration writes
  input  logic                               cfg_we,
  input  logic [ssd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ssd_pkg::*;

  cfg_t                 cfg_r;
  logic                 s_vld_r;
  logic [SAMPLE_W-1:0]  s_sample_r;
  logic                 s_last_r;
  logic                 out_vld_r;
  result_t              res_r;

  logic                 out_free;
  logic                 advance;
  logic                 active;
  logic                 emit;
  result_t              res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain            <= GAIN_RST;
      cfg_r.level           <= LEVEL_RST;
      cfg_r.gap_limit       <= GAP_RST;
      cfg_r.min_word_length <= MINLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GAIN:     cfg_r.gain            <= cfg_wdata[GAIN_W-1:0];
        CFG_LEVEL:    cfg_r.level           <= cfg_wdata[LEVEL_W-1:0];
        CFG_GAP:      cfg_r.gap_limit       <= cfg_wdata[GAP_W-1:0];
        CFG_MIN_WORD: cfg_r.min_word_length <= cfg_wdata[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register drains when the result register can take a beat
  assign out_free  = !out_vld_r || out_tready;
  assign advance   = s_vld_r && out_free;
  assign in_tready = !s_vld_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s_vld_r <= 1'b1;
    end else if (advance) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_sample_r <= in_tdata;
      s_last_r   <= in_tlast;
    end
  end

  ssd_activity u_activity (
    .sample (s_sample_r),
    .cfg    (cfg_r),
    .active (active)
  );

  ssd_tracker #(
    .INDEX_BITS (INDEX_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .step   (advance),
    .active (active),
    .last   (s_last_r),
    .emit   (emit),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, res_r.word_count, res_r.word_length, res_r.word_start};
  assign out_tuser  = res_r.has_word;
  assign out_tlast  = res_r.final_res;

endmodule

// ----- bench/tb_speech_segment_detector_core.sv -----
`timescale 1ns / 1ps

module tb_speech_segment_detector_core;
  import ssd_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  // tracks the word detector state and queues the result beats it predicts
  class word_tracker;
    cfg_t             regs;
    logic [23:0]      idx;
    logic [23:0]      word_begin;
    logic [23:0]      last_sound;
    logic [23:0]      words_found;
    logic [SIL_W-1:0] silence;
    bit               in_word;
    result_t          expected_words[$];
    int               faults;

    function new();
      regs = '{GAIN_RST, LEVEL_RST, GAP_RST, MINLEN_RST};
      faults = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      idx = '0;
      word_begin = '0;
      last_sound = '0;
      words_found = '0;
      silence = '0;
      in_word = 1'b0;
    endfunction

    // scaled magnitude against the sound level
    function bit is_sound(logic [15:0] s);
      logic [16:0] mag_in;
      logic [26:0] prod;
      mag_in = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
      prod = mag_in * regs.gain;
      return (prod >> SHIFT) >= regs.level;
    endfunction

    // log-uniform magnitudes, retried until the wanted activity comes up
    function logic [15:0] pick_sample(bit want_sound);
      logic [15:0] s;
      int unsigned w;
      s = '0;
      for (int t = 0; t < 40; t++) begin
        w = $urandom_range(0, 16);
        s = 16'($urandom & ((32'd1 << w) - 1));
        if ($urandom_range(0, 1)) s = -s;
        if (is_sound(s) == want_sound) return s;
      end
      return s;
    endfunction

    function void take_sample(logic [15:0] s, bit last);
      result_t     r;
      bit          has;
      logic [24:0] span;
      r = '0;
      has = 1'b0;
      if (is_sound(s)) begin
        // open a word, pulling in a short leading silence
        if (!in_word) begin
          word_begin = (silence <= regs.gap_limit) ? idx - 24'(silence) : idx;
          in_word = 1'b1;
        end
        last_sound = idx;
        silence = '0;
        if (last) begin
          has = 1'b1;
          r.word_start = word_begin;
          r.word_length = {1'b0, idx - word_begin} + 25'd1;
        end
      end else begin
        if (silence != SIL_MAX) silence = silence + 1'b1;
        // close on a long gap or at the end of the stream, with the length check
        if (in_word && (silence > regs.gap_limit || last)) begin
          span = {1'b0, last_sound - word_begin} + 25'd1;
          if (span > regs.min_word_length) begin
            has = 1'b1;
            r.word_start = word_begin;
            r.word_length = span;
          end
          in_word = 1'b0;
        end
      end
      if (has) words_found = words_found + 1'b1;
      idx = idx + 1'b1;
      if (has || last) begin
        r.has_word = has;
        r.word_count = words_found;
        r.final_res = last;
        expected_words.push_back(r);
      end
      if (last) clear_stream();
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result beat with nothing expected: has_word %0d word_start %0d word_count %0d",
               got.has_word, got.word_start, got.word_count);
        faults++;
        return;
      end
      want = expected_words.pop_front();
      if (got.has_word !== want.has_word) begin
        $error("has_word: expected %0d, got %0d", want.has_word, got.has_word);
        faults++;
      end
      if (got.word_start !== want.word_start) begin
        $error("word_start: expected %0d, got %0d", want.word_start, got.word_start);
        faults++;
      end
      if (got.word_length !== want.word_length) begin
        $error("word_length: expected %0d, got %0d", want.word_length, got.word_length);
        faults++;
      end
      if (got.word_count !== want.word_count) begin
        $error("word_count: expected %0d, got %0d", want.word_count, got.word_count);
        faults++;
      end
      if (got.final_res !== want.final_res) begin
        $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
        faults++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;    // sample[15:0]
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // word_start[23:0], word_length[48:24],
                                      // word_count[72:49], zeros[79:73]
  logic                  out_tuser;   // has_word
  logic                  out_tlast;   // final_res
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  word_tracker track;
  int          send_idle_pct;
  int          ready_stall_pct;
  int          cycle_count = 0;

  speech_segment_detector_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("speech_segment_detector_core: mismatch");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // check result beats, then record accepted samples
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      track.check_word('{has_word: out_tuser, word_start: out_tdata[23:0],
                         word_length: out_tdata[48:24], word_count: out_tdata[72:49],
                         final_res: out_tlast});
    end
    if (rst_n && in_tvalid && in_tready) track.take_sample(in_tdata, in_tlast);
  end

  task automatic send_sample(input logic [15:0] s, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic play_stream(input logic [15:0] seq[$], input bit ends);
    foreach (seq[k]) send_sample(seq[k], ends && (k == seq.size() - 1));
  endtask

  // hold off the sender until every expected beat is in and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (track.expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_regs(input logic [9:0] g, input logic [9:0] lv,
                           input logic [15:0] gap, input logic [15:0] mn);
    logic [CFG_ADDR_W-1:0] addrs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    addrs = '{CFG_GAIN, CFG_LEVEL, CFG_GAP, CFG_MIN_WORD};
    vals = '{{6'd0, g}, {6'd0, lv}, gap, mn};
    for (int r = 0; r < 4; r++) begin
      cfg_we <= 1'b1;
      cfg_addr <= addrs[r];
      cfg_wdata <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    track.regs = '{g, lv, gap, mn};
  endtask

  // runs of sound and silence sized around the gap limit, with some noise mixed in
  task automatic random_stream(input int n_items);
    int          sent;
    int          run;
    int          gap_cap;
    bit          sound;
    logic [15:0] s;
    sent = 0;
    sound = $urandom_range(0, 1);
    gap_cap = (track.regs.gap_limit > 8) ? 8 : int'(track.regs.gap_limit);
    while (sent < n_items) begin
      run = sound ? $urandom_range(1, 6) : $urandom_range(0, gap_cap + 3);
      for (int k = 0; k < run && sent < n_items; k++) begin
        s = ($urandom_range(0, 99) < 12) ? 16'($urandom) : track.pick_sample(sound);
        send_sample(s, sent == n_items - 1);
        sent++;
      end
      sound = !sound;
    end
  endtask

  initial begin
    int          send_pcts [4];
    int          stall_pcts [4];
    int          items;
    int          n;
    logic [9:0]  g;
    logic [9:0]  lv;
    logic [15:0] gp;
    logic [15:0] mn;

    track = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_GAIN;
    cfg_wdata <= '0;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    send_pcts = '{0, 73, 0, 31};
    stall_pcts = '{0, 0, 73, 31};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: a short word ending on an active last sample
    play_stream('{16'h7FFF, 16'h0000, 16'h8000}, 1'b1);

    // threshold sits between 16400 and 16401; gap and minimum length of two
    settle();
    load_regs(10'd1023, 10'd512, 16'd2, 16'd2);
    // bridged leading silence, word closed by a long gap, then an active last sample
    play_stream('{16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h4011,
                  16'h0000, 16'h0000, 16'h0000, 16'hBFEF}, 1'b1);
    // short word dropped, then a register change in the middle of a word
    play_stream('{16'h7FFF, 16'h4010, 16'hBFF0, 16'hFFFF, 16'h8000}, 1'b0);
    settle();
    load_regs(10'd1023, 10'd1023, 16'd2, 16'd2);
    // silent last sample closes a short word: end marker only
    play_stream('{16'h7FFF, 16'h0000}, 1'b1);

    // level zero: every sample is sound
    settle();
    load_regs(10'd1023, 10'd0, 16'd0, 16'd0);
    play_stream('{16'h0000, 16'h0000}, 1'b1);

    // zero gain: nothing is sound
    settle();
    load_regs(10'd0, 10'd1, 16'd0, 16'd0);
    play_stream('{16'h7FFF, 16'h8000}, 1'b1);

    // leading silence right at the gap limit is bridged, one sample more closes the word
    settle();
    load_regs(10'd1023, 10'd1023, 16'd40, 16'd0);
    for (int k = 0; k < 40; k++) send_sample(track.pick_sample(1'b0), 1'b0);
    send_sample(16'h8000, 1'b0);
    for (int k = 0; k < 41; k++) send_sample(track.pick_sample(1'b0), 1'b0);
    send_sample(16'h8000, 1'b1);

    // random streams under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      items = 0;
      while (items < 80) begin
        if (items == 0 || $urandom_range(0, 2) == 0) begin
          settle();
          send_idle_pct = send_pcts[ph];
          ready_stall_pct = stall_pcts[ph];
          case ($urandom_range(0, 5))
            0:       g = 10'd0;
            1:       g = 10'd1023;
            default: g = 10'($urandom_range(1, 1023));
          endcase
          case ($urandom_range(0, 6))
            0:       lv = 10'd0;
            1:       lv = 10'd1;
            2:       lv = 10'd1023;
            default: lv = 10'($urandom_range(1, 64));
          endcase
          case ($urandom_range(0, 5))
            0:       gp = 16'd0;
            1:       gp = 16'hFFFF;
            default: gp = 16'($urandom_range(0, 6));
          endcase
          case ($urandom_range(0, 5))
            0:       mn = 16'd0;
            1:       mn = 16'hFFFF;
            default: mn = 16'($urandom_range(0, 8));
          endcase
          load_regs(g, lv, gp, mn);
        end
        n = $urandom_range(1, 30);
        random_stream(n);
        items += n;
      end
    end

    settle();
    if (track.faults == 0) begin
      $display("speech_segment_detector_core: match");
    end else begin
      $display("speech_segment_detector_core: mismatch");
    end
    $finish;
  end

endmodule
